@@ sv/dlsc_pkg.sv @@
// Package for the display line status controller.
// Holds operation codes, status bit positions and field widths; no dependencies.
package dlsc_pkg;

	localparam int LINE_W = 9;
	localparam int DATA_W = 16;
	localparam int OP_W = 2;
	localparam int IRQ_W = 3;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	localparam logic [DATA_W-1:0] WRITABLE_MASK = 16'hffb8;

	localparam int BIT_FLAG_VBLANK = 0;
	localparam int BIT_FLAG_HBLANK = 1;
	localparam int BIT_FLAG_MATCH = 2;
	localparam int BIT_EN_VBLANK = 3;
	localparam int BIT_EN_HBLANK = 4;
	localparam int BIT_EN_MATCH = 5;
	localparam int BIT_WATCH_HIGH = 7;

	localparam int REQ_VBLANK = 0;
	localparam int REQ_HBLANK = 1;
	localparam int REQ_MATCH = 2;

	typedef logic [DATA_W-1:0] status_t;
	typedef logic [LINE_W-1:0] line_t;

	function automatic line_t compare_line(input status_t s);
		compare_line = {s[BIT_WATCH_HIGH], s[15:8]};
	endfunction

endpackage

@@ sv/display_line_status_controller.sv @@
// Top level of the display line status controller.
// Depends on dlsc_pkg for operation codes, status layout and widths.
//
// Each accepted word is a line tick, a status read or a status write for the main
// or the secondary side, and it produces exactly one result word in the next cycle.
// A new word is accepted in every cycle while the result register is empty or is
// being taken in the same cycle, so the block sustains one word per clock; the only
// stall comes from the output side holding ready low. The line counter and both
// status registers live in flip-flops and are updated at acceptance, and the result
// register holds the requests, read value and line number that the word caused.
module display_line_status_controller #(
	parameter int VISIBLE_LINE_COUNT = 192,
	parameter int TOTAL_LINE_COUNT = 263
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dlsc_pkg::OP_W-1:0]     operation,
	input  logic                          side,
	input  logic [dlsc_pkg::DATA_W-1:0]   write_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dlsc_pkg::DATA_W-1:0]   read_data,
	output logic [dlsc_pkg::IRQ_W-1:0]    irq_main,
	output logic [dlsc_pkg::IRQ_W-1:0]    irq_secondary,
	output logic [dlsc_pkg::LINE_W-1:0]   current_line
);

	localparam dlsc_pkg::line_t VISIBLE_LINE = dlsc_pkg::LINE_W'(VISIBLE_LINE_COUNT);
	localparam dlsc_pkg::line_t LAST_LINE = dlsc_pkg::LINE_W'(TOTAL_LINE_COUNT - 1);

	dlsc_pkg::line_t line_q;
	dlsc_pkg::status_t status_q [2];
	logic out_valid_q;
	dlsc_pkg::status_t read_data_q;
	logic [dlsc_pkg::IRQ_W-1:0] irq_main_q;
	logic [dlsc_pkg::IRQ_W-1:0] irq_secondary_q;
	dlsc_pkg::line_t current_line_q;

	logic in_fire;
	dlsc_pkg::line_t line_next;
	dlsc_pkg::status_t read_value;
	logic [dlsc_pkg::IRQ_W-1:0] irq_next [2];

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		dlsc_pkg::status_t sel;
		line_next = line_q;
		read_value = '0;
		irq_next[0] = '0;
		irq_next[1] = '0;
		sel = status_q[side];
		case (operation)
			dlsc_pkg::OP_TICK: begin
				line_next = (line_q == LAST_LINE) ? '0 : line_q + dlsc_pkg::LINE_W'(1);
				for (int k = 0; k < 2; k++) begin
					irq_next[k][dlsc_pkg::REQ_HBLANK] = status_q[k][dlsc_pkg::BIT_EN_HBLANK];
					irq_next[k][dlsc_pkg::REQ_VBLANK] = (line_next == VISIBLE_LINE)
						&& status_q[k][dlsc_pkg::BIT_EN_VBLANK];
					irq_next[k][dlsc_pkg::REQ_MATCH] =
						(line_next == dlsc_pkg::compare_line(status_q[k]))
						&& status_q[k][dlsc_pkg::BIT_EN_MATCH];
				end
			end
			dlsc_pkg::OP_READ: begin
				read_value = sel;
				read_value[dlsc_pkg::BIT_FLAG_VBLANK] = (line_q >= VISIBLE_LINE)
					&& (line_q != LAST_LINE);
				read_value[dlsc_pkg::BIT_FLAG_MATCH] = (line_q == dlsc_pkg::compare_line(sel));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			status_q[0] <= '0;
			status_q[1] <= '0;
		end else if (in_fire) begin
			line_q <= line_next;
			if (operation == dlsc_pkg::OP_WRITE) begin
				status_q[side] <= write_data & dlsc_pkg::WRITABLE_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			read_data_q <= read_value;
			irq_main_q <= irq_next[0];
			irq_secondary_q <= irq_next[1];
			current_line_q <= line_next;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_main = irq_main_q;
	assign irq_secondary = irq_secondary_q;
	assign current_line = current_line_q;

	a_line_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LAST_LINE)
		else $error("Line counter left the frame.");

	a_no_irq_off_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && operation != dlsc_pkg::OP_TICK
		|=> irq_main == '0 && irq_secondary == '0)
		else $error("Requests raised by a word that is not a tick.");

	a_read_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && operation != dlsc_pkg::OP_READ |=> read_data == '0)
		else $error("Read data nonzero for a word that is not a read.");

	a_hblank_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !read_data[dlsc_pkg::BIT_FLAG_HBLANK])
		else $error("Hblank flag seen in read data.");

endmodule
